/* hdl/owm_pkg.sv */
// Shared types and constants for the 1-Wire bus master.
`timescale 1ns / 1ps

package owm_pkg;

	// Command codes carried on func.
	localparam logic [2:0] FN_RESET      = 3'd0;
	localparam logic [2:0] FN_WRITE_BYTE = 3'd1;
	localparam logic [2:0] FN_READ_BYTE  = 3'd2;
	localparam logic [2:0] FN_WRITE_BIT  = 3'd3;
	localparam logic [2:0] FN_READ_BIT   = 3'd4;
	localparam logic [2:0] FN_WAIT_HIGH  = 3'd5;

	// Timing register indexes.
	localparam logic [2:0] CFG_SHORT_LOW     = 3'd0;
	localparam logic [2:0] CFG_W1_RELEASE    = 3'd1;
	localparam logic [2:0] CFG_W0_LOW        = 3'd2;
	localparam logic [2:0] CFG_W0_RELEASE    = 3'd3;
	localparam logic [2:0] CFG_READ_SAMPLE   = 3'd4;
	localparam logic [2:0] CFG_READ_TAIL     = 3'd5;
	localparam logic [2:0] CFG_RESET_LOW     = 3'd6;
	localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd7;

	localparam int unsigned TICK_W = 10;

	// Bus sequencer phases.
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_SLOT_LOW  = 4'd1,
		PH_WRITE_REL = 4'd2,
		PH_READ_WAIT = 4'd3,
		PH_READ_TAIL = 4'd4,
		PH_RST_LOW   = 4'd5,
		PH_RST_WAIT  = 4'd6,
		PH_RST_RECOV = 4'd7,
		PH_WAIT_HIGH = 4'd8
	} phase_t;

	// Timing register file contents.
	typedef struct packed {
		logic [TICK_W-1:0] short_low_ticks;
		logic [TICK_W-1:0] write_one_release_ticks;
		logic [TICK_W-1:0] write_zero_low_ticks;
		logic [TICK_W-1:0] write_zero_release_ticks;
		logic [TICK_W-1:0] read_sample_ticks;
		logic [TICK_W-1:0] read_tail_ticks;
		logic [TICK_W-1:0] reset_low_ticks;
		logic [TICK_W-1:0] presence_wait_ticks;
	} cfg_t;

	// Sequencer state held between words.
	typedef struct packed {
		phase_t            phase;
		logic [TICK_W-1:0] tick_count;
		logic [3:0]        bits_left;
		logic [7:0]        shift_byte;
		logic [2:0]        active_func;
		logic [7:0]        read_byte;
		logic              presence_flag;
	} state_t;

	// One input word.
	typedef struct packed {
		logic       go;
		logic [2:0] func;
		logic [7:0] data_in;
		logic       line_sample;
	} item_t;

	// One result word.
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       presence_missing;
	} result_t;

endpackage

/* hdl/onewire_bus_master.sv */
// Top level of the 1-Wire bus master: input register, sequencer state, result register.
`timescale 1ns / 1ps

// Each input word is one bus tick and gives exactly one result word, in order.
// A word passes an input register, one pass of the sequencer step logic, and a
// result register, and its result word is offered from the result register.
// With the output side taking words, one word is accepted every cycle,
// and in_ready falls only while the result register holds a word that is not
// taken. The step logic (window length select, 10-bit tick compare) between
// the two registers sets the clock rate. Timing registers are written through
// cfg_we/cfg_index/cfg_data and should only change while no command runs.
// RESET_RECOVERY_TICKS sets the released time after the presence sample.
module onewire_bus_master #(
	parameter int unsigned RESET_RECOVERY_TICKS = 269
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        go,
	input  logic [2:0]  func,
	input  logic [7:0]  data_in,
	input  logic        line_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        drive_low,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        presence_missing
);

	owm_pkg::cfg_t    cfg;
	owm_pkg::item_t   item_s1;
	logic             valid_s1;
	owm_pkg::state_t  state_q;
	owm_pkg::state_t  state_nxt;
	owm_pkg::result_t res_nxt;
	owm_pkg::result_t res_s2;
	logic             valid_s2;
	logic             advance;

	owm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The held word moves on when the result register is empty or being read.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.go          <= go;
			item_s1.func        <= func;
			item_s1.data_in     <= data_in;
			item_s1.line_sample <= line_sample;
		end
	end

	owm_step #(
		.RESET_RECOVERY_TICKS (RESET_RECOVERY_TICKS)
	) u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Sequencer state register, updated once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= owm_pkg::PH_IDLE;
			state_q.tick_count    <= '0;
			state_q.bits_left     <= '0;
			state_q.shift_byte    <= '0;
			state_q.active_func   <= owm_pkg::FN_RESET;
			state_q.read_byte     <= '0;
			state_q.presence_flag <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid        = valid_s2;
	assign drive_low        = res_s2.drive_low;
	assign busy_res         = res_s2.busy_res;
	assign done_res         = res_s2.done_res;
	assign read_data        = res_s2.read_data;
	assign presence_missing = res_s2.presence_missing;

endmodule

/* hdl/owm_cfg_regs.sv */
// Timing register file of the 1-Wire bus master.
`timescale 1ns / 1ps

module owm_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [owm_pkg::TICK_W-1:0]  cfg_data,
	output owm_pkg::cfg_t               cfg
);

	owm_pkg::cfg_t cfg_q;

	// Registers come out of reset with standard-speed slot timing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_low_ticks          <= 10'd4;
			cfg_q.write_one_release_ticks  <= 10'd42;
			cfg_q.write_zero_low_ticks     <= 10'd40;
			cfg_q.write_zero_release_ticks <= 10'd7;
			cfg_q.read_sample_ticks        <= 10'd6;
			cfg_q.read_tail_ticks          <= 10'd37;
			cfg_q.reset_low_ticks          <= 10'd315;
			cfg_q.presence_wait_ticks      <= 10'd46;
		end else if (cfg_we) begin
			case (cfg_index)
				owm_pkg::CFG_SHORT_LOW:     cfg_q.short_low_ticks          <= cfg_data;
				owm_pkg::CFG_W1_RELEASE:    cfg_q.write_one_release_ticks  <= cfg_data;
				owm_pkg::CFG_W0_LOW:        cfg_q.write_zero_low_ticks     <= cfg_data;
				owm_pkg::CFG_W0_RELEASE:    cfg_q.write_zero_release_ticks <= cfg_data;
				owm_pkg::CFG_READ_SAMPLE:   cfg_q.read_sample_ticks        <= cfg_data;
				owm_pkg::CFG_READ_TAIL:     cfg_q.read_tail_ticks          <= cfg_data;
				owm_pkg::CFG_RESET_LOW:     cfg_q.reset_low_ticks          <= cfg_data;
				owm_pkg::CFG_PRESENCE_WAIT: cfg_q.presence_wait_ticks      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/owm_step.sv */
// Next-state and result logic for one bus tick of the 1-Wire master.
`timescale 1ns / 1ps

module owm_step #(
	parameter int unsigned RESET_RECOVERY_TICKS = 269
) (
	input  owm_pkg::cfg_t    cfg,
	input  owm_pkg::state_t  cur,
	input  owm_pkg::item_t   item,
	output owm_pkg::state_t  nxt,
	output owm_pkg::result_t res
);

	localparam logic [owm_pkg::TICK_W-1:0] RECOV_LEN =
		owm_pkg::TICK_W'(RESET_RECOVERY_TICKS);

	always_comb begin
		logic                         start;
		logic                         is_rd;
		logic                         drive;
		logic                         done;
		logic [owm_pkg::TICK_W-1:0]   len;
		logic [owm_pkg::TICK_W-1:0]   tc_inc;

		nxt   = cur;
		drive = 1'b0;
		done  = 1'b0;

		// Command start: the start tick is already the first tick of the command.
		start = (cur.phase == owm_pkg::PH_IDLE) && item.go &&
			(item.func <= owm_pkg::FN_WAIT_HIGH);
		if (start) begin
			nxt.active_func = item.func;
			nxt.tick_count  = '0;
			case (item.func)
				owm_pkg::FN_RESET: begin
					nxt.phase = owm_pkg::PH_RST_LOW;
				end
				owm_pkg::FN_WRITE_BYTE: begin
					nxt.shift_byte = item.data_in;
					nxt.bits_left  = 4'd8;
					nxt.phase      = owm_pkg::PH_SLOT_LOW;
				end
				owm_pkg::FN_READ_BYTE: begin
					nxt.shift_byte = 8'h00;
					nxt.bits_left  = 4'd8;
					nxt.phase      = owm_pkg::PH_SLOT_LOW;
				end
				owm_pkg::FN_WRITE_BIT: begin
					nxt.shift_byte = {7'd0, item.data_in[0]};
					nxt.bits_left  = 4'd1;
					nxt.phase      = owm_pkg::PH_SLOT_LOW;
				end
				owm_pkg::FN_READ_BIT: begin
					nxt.shift_byte = 8'h00;
					nxt.bits_left  = 4'd1;
					nxt.phase      = owm_pkg::PH_SLOT_LOW;
				end
				default: begin
					nxt.phase = owm_pkg::PH_WAIT_HIGH;
				end
			endcase
		end

		is_rd = (nxt.active_func == owm_pkg::FN_READ_BYTE) ||
			(nxt.active_func == owm_pkg::FN_READ_BIT);

		// Length of the current timing window.
		case (nxt.phase)
			owm_pkg::PH_SLOT_LOW:
				len = (is_rd || nxt.shift_byte[0]) ? cfg.short_low_ticks
					: cfg.write_zero_low_ticks;
			owm_pkg::PH_WRITE_REL:
				len = nxt.shift_byte[0] ? cfg.write_one_release_ticks
					: cfg.write_zero_release_ticks;
			owm_pkg::PH_READ_WAIT: len = cfg.read_sample_ticks;
			owm_pkg::PH_READ_TAIL: len = cfg.read_tail_ticks;
			owm_pkg::PH_RST_LOW:   len = cfg.reset_low_ticks;
			owm_pkg::PH_RST_WAIT:  len = cfg.presence_wait_ticks;
			owm_pkg::PH_RST_RECOV: len = RECOV_LEN;
			default:               len = owm_pkg::TICK_W'(1);
		endcase

		tc_inc = nxt.tick_count + owm_pkg::TICK_W'(1);

		if (nxt.phase == owm_pkg::PH_WAIT_HIGH) begin
			// Conversion poll: finish on the first high line, never drive.
			if (item.line_sample) begin
				nxt.phase = owm_pkg::PH_IDLE;
				done      = 1'b1;
			end
		end else if (nxt.phase != owm_pkg::PH_IDLE) begin
			drive = (nxt.phase == owm_pkg::PH_SLOT_LOW) ||
				(nxt.phase == owm_pkg::PH_RST_LOW);

			// Sample the line on the first tick of the read tail or recovery.
			if (nxt.tick_count == '0) begin
				if (nxt.phase == owm_pkg::PH_READ_TAIL)
					nxt.shift_byte = {item.line_sample, nxt.shift_byte[7:1]};
				else if (nxt.phase == owm_pkg::PH_RST_RECOV)
					nxt.presence_flag = item.line_sample;
			end

			// Window end advances the phase; otherwise keep counting.
			if (tc_inc >= len) begin
				nxt.tick_count = '0;
				case (nxt.phase)
					owm_pkg::PH_SLOT_LOW: begin
						nxt.phase = is_rd ? owm_pkg::PH_READ_WAIT : owm_pkg::PH_WRITE_REL;
					end
					owm_pkg::PH_READ_WAIT: begin
						nxt.phase = owm_pkg::PH_READ_TAIL;
					end
					owm_pkg::PH_WRITE_REL,
					owm_pkg::PH_READ_TAIL: begin
						nxt.bits_left = nxt.bits_left - 4'd1;
						if (!is_rd)
							nxt.shift_byte = {1'b0, nxt.shift_byte[7:1]};
						if (nxt.bits_left == 4'd0) begin
							if (is_rd)
								nxt.read_byte = nxt.shift_byte;
							nxt.phase = owm_pkg::PH_IDLE;
							done      = 1'b1;
						end else begin
							nxt.phase = owm_pkg::PH_SLOT_LOW;
						end
					end
					owm_pkg::PH_RST_LOW: begin
						nxt.phase = owm_pkg::PH_RST_WAIT;
					end
					owm_pkg::PH_RST_WAIT: begin
						nxt.phase = owm_pkg::PH_RST_RECOV;
					end
					default: begin
						nxt.phase = owm_pkg::PH_IDLE;
						done      = 1'b1;
					end
				endcase
			end else begin
				nxt.tick_count = tc_inc;
			end
		end

		res.drive_low        = drive;
		res.busy_res         = (nxt.phase != owm_pkg::PH_IDLE);
		res.done_res         = done;
		res.read_data        = nxt.read_byte;
		res.presence_missing = nxt.presence_flag;
	end

endmodule

/* hdl/owm_checker.sv */
// Port-level checks for the 1-Wire bus master, bound to the top level.
`timescale 1ns / 1ps

module owm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       drive_low,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data,
	input logic       presence_missing
);

	// A finished command is never reported as still running.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done_res with busy_res");

	// The line is only pulled low while a command is running.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_low |-> busy_res)
		else $error("drive_low outside a command");

	// An empty result register never stalls the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty output");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_low) &&
		$stable(busy_res) && $stable(done_res) && $stable(read_data) &&
		$stable(presence_missing))
		else $error("result word changed while stalled");

endmodule

bind onewire_bus_master owm_checker u_owm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.drive_low        (drive_low),
	.busy_res         (busy_res),
	.done_res         (done_res),
	.read_data        (read_data),
	.presence_missing (presence_missing)
);
